### rtl/mtep_pkg.sv
package mtep_pkg;

  // Field widths
  localparam int unsigned DELTA_W = 28;
  localparam int unsigned UPT_W   = 24;
  localparam int unsigned TPQ_W   = 15;
  localparam int unsigned DELAY_W = 52;
  localparam int unsigned CNT_W   = 5;

  // Reset and default values
  localparam logic [UPT_W-1:0] DEFAULT_TEMPO = 24'd500000;
  localparam logic [UPT_W-1:0] UPT_RESET     = 24'd5208;
  localparam logic [TPQ_W-1:0] TPQ_RESET     = 15'd96;

  // Byte codes
  localparam logic [7:0] DATA_MASK   = 8'h7F;
  localparam logic [7:0] STATUS_MIN  = 8'h80;
  localparam logic [7:0] SYSTEM_MIN  = 8'hF0;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [3:0] CLASS_PROG  = 4'hC;
  localparam logic [3:0] CLASS_PRESS = 4'hD;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_META    = 2'd1,
    KIND_EOT     = 2'd2,
    KIND_SYSEX   = 2'd3
  } kind_t;

  // Which fields make up a result
  typedef enum logic [1:0] {
    SEL_CH_ONE = 2'd0,
    SEL_CH_TWO = 2'd1,
    SEL_META   = 2'd2,
    SEL_SYSEX  = 2'd3
  } sel_t;

  typedef struct packed {
    logic       track_start;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [DELAY_W-1:0] delay_us;
    logic [7:0]         status_byte;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic               has_second;
  } out_t;

  // Controller to datapath, per accepted byte
  typedef struct packed {
    logic  restart;
    logic  delta;
    logic  take_status;
    logic  run_data;
    logic  hold_data;
    logic  meta_type;
    logic  meta_len;
    logic  meta_body;
    logic  emit;
    kind_t kind;
    sel_t  sel;
    logic  div_start;
    logic  div_default;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic two_data;
    logic meta_eot;
    logic meta_tempo;
    logic body_last;
  } stat_t;

endpackage

### rtl/mtep_div.sv
module mtep_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mtep_pkg::UPT_W-1:0]    dividend,
  input  logic [mtep_pkg::TPQ_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [mtep_pkg::UPT_W-1:0]    quotient
);

  localparam logic [mtep_pkg::CNT_W-1:0] LAST_STEP = mtep_pkg::CNT_W'(mtep_pkg::UPT_W - 1);

  logic [mtep_pkg::UPT_W-1:0] quo_r, quo_nxt;
  logic [mtep_pkg::TPQ_W-1:0] rem_r, rem_nxt;
  logic [mtep_pkg::TPQ_W-1:0] dvs_r;
  logic [mtep_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r, done_r;
  logic [mtep_pkg::TPQ_W:0]   trial;
  logic [mtep_pkg::TPQ_W:0]   diff;
  logic                       fits;

  // One restoring step: one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[mtep_pkg::UPT_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[mtep_pkg::TPQ_W-1:0] : trial[mtep_pkg::TPQ_W-1:0];
    quo_nxt = {quo_r[mtep_pkg::UPT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands; a zero divisor counts as one
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= (divisor == '0) ? mtep_pkg::TPQ_W'(1) : divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Busy until the quotient has been taken up as the new tick length
  assign busy     = busy_r || done_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/mtep_ctrl.sv
module mtep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  mtep_pkg::in_t     in_data,
  input  mtep_pkg::stat_t   stat,
  output mtep_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_BODY,
    PH_HALT
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_eff;
  logic [7:0] b;

  assign b = in_data.data_byte;

  // Decode the byte against the phase; a restart begins from the delta time
  always_comb begin
    cmd       = '0;
    cmd.kind  = mtep_pkg::KIND_CHANNEL;
    cmd.sel   = mtep_pkg::SEL_CH_ONE;
    phase_eff = in_data.track_start ? PH_DELTA : phase_r;
    phase_nxt = phase_eff;
    if (in_data.track_start) begin
      cmd.restart     = 1'b1;
      cmd.div_start   = 1'b1;
      cmd.div_default = 1'b1;
    end
    unique case (phase_eff)
      PH_DELTA: begin
        cmd.delta = 1'b1;
        if (!b[7]) phase_nxt = PH_STATUS;
      end
      PH_STATUS: begin
        if (b < mtep_pkg::STATUS_MIN) begin
          // running status
          cmd.run_data = 1'b1;
          if (stat.two_data) begin
            phase_nxt = PH_DATA2;
          end else begin
            cmd.emit  = 1'b1;
            phase_nxt = PH_DELTA;
          end
        end else if (b == mtep_pkg::META_STATUS) begin
          phase_nxt = PH_META_TYPE;
        end else if (b >= mtep_pkg::SYSTEM_MIN) begin
          cmd.emit  = 1'b1;
          cmd.kind  = mtep_pkg::KIND_SYSEX;
          cmd.sel   = mtep_pkg::SEL_SYSEX;
          phase_nxt = PH_HALT;
        end else begin
          cmd.take_status = 1'b1;
          phase_nxt       = PH_DATA1;
        end
      end
      PH_DATA1: begin
        cmd.hold_data = 1'b1;
        if (stat.two_data) begin
          phase_nxt = PH_DATA2;
        end else begin
          cmd.emit  = 1'b1;
          phase_nxt = PH_DELTA;
        end
      end
      PH_DATA2: begin
        cmd.emit  = 1'b1;
        cmd.sel   = mtep_pkg::SEL_CH_TWO;
        phase_nxt = PH_DELTA;
      end
      PH_META_TYPE: begin
        cmd.meta_type = 1'b1;
        phase_nxt     = PH_META_LEN;
      end
      PH_META_LEN: begin
        cmd.meta_len = 1'b1;
        if (b == '0) begin
          cmd.emit  = 1'b1;
          cmd.sel   = mtep_pkg::SEL_META;
          cmd.kind  = stat.meta_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_META;
          phase_nxt = stat.meta_eot ? PH_HALT : PH_DELTA;
        end else begin
          phase_nxt = PH_META_BODY;
        end
      end
      PH_META_BODY: begin
        cmd.meta_body = 1'b1;
        if (stat.body_last) begin
          cmd.emit      = 1'b1;
          cmd.sel       = mtep_pkg::SEL_META;
          cmd.kind      = stat.meta_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_META;
          cmd.div_start = stat.meta_tempo;
          phase_nxt     = stat.meta_eot ? PH_HALT : PH_DELTA;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/mtep_dpath.sv
module mtep_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  mtep_pkg::in_t                 in_data,
  input  mtep_pkg::cmd_t                cmd,
  output mtep_pkg::stat_t               stat,
  input  logic                          cfg_wr_en,
  input  logic [mtep_pkg::TPQ_W-1:0]    cfg_wr_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output mtep_pkg::out_t                out_data,
  output logic                          div_busy
);

  logic [mtep_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic [mtep_pkg::UPT_W-1:0]   upt_r;
  logic [mtep_pkg::UPT_W-1:0]   tempo_r, tempo_nxt, tempo_base;
  logic [mtep_pkg::TPQ_W-1:0]   tpq_r;
  logic [7:0]                   run_st_r, run_st_nxt;
  logic [7:0]                   held_r, held_nxt;
  logic [7:0]                   meta_r, meta_nxt;
  logic [7:0]                   left_r, left_nxt;
  logic [7:0]                   b;
  logic                         out_valid_r;
  mtep_pkg::out_t               out_r;
  logic [mtep_pkg::DELAY_W-1:0] product;
  logic                         div_done;
  logic [mtep_pkg::UPT_W-1:0]   div_quo;
  logic [mtep_pkg::UPT_W-1:0]   div_dividend;

  assign b = in_data.data_byte;

  // Flags for the controller
  always_comb begin
    stat.two_data   = (run_st_r[7:4] != mtep_pkg::CLASS_PROG) &&
                      (run_st_r[7:4] != mtep_pkg::CLASS_PRESS);
    stat.meta_eot   = (meta_r == mtep_pkg::META_EOT);
    stat.meta_tempo = (meta_r == mtep_pkg::META_TEMPO);
    stat.body_last  = (left_r == 8'd1);
  end

  // Next parser registers; restart clears before the byte is applied
  always_comb begin
    delta_nxt  = cmd.restart ? '0 : delta_r;
    tempo_base = cmd.restart ? '0 : tempo_r;
    tempo_nxt  = tempo_base;
    run_st_nxt = cmd.restart ? '0 : run_st_r;
    held_nxt   = cmd.restart ? '0 : held_r;
    meta_nxt   = cmd.restart ? '0 : meta_r;
    left_nxt   = cmd.restart ? '0 : left_r;
    if (cmd.delta) begin
      delta_nxt = {delta_nxt[mtep_pkg::DELTA_W-8:0], b[6:0]};
    end
    if (cmd.take_status) run_st_nxt = b;
    if (cmd.run_data || cmd.hold_data) held_nxt = b;
    if (cmd.meta_type) meta_nxt = b;
    if (cmd.meta_len) begin
      left_nxt  = b;
      tempo_nxt = '0;
    end
    if (cmd.meta_body) begin
      left_nxt = left_r - 8'd1;
      if (stat.meta_tempo) tempo_nxt = {tempo_r[mtep_pkg::UPT_W-9:0], b};
    end
    if (cmd.emit) delta_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r  <= '0;
      tempo_r  <= '0;
      run_st_r <= '0;
      held_r   <= '0;
      meta_r   <= '0;
      left_r   <= '0;
    end else if (accept) begin
      delta_r  <= delta_nxt;
      tempo_r  <= tempo_nxt;
      run_st_r <= run_st_nxt;
      held_r   <= held_nxt;
      meta_r   <= meta_nxt;
      left_r   <= left_nxt;
    end
  end

  // Division register and tempo in force
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r <= mtep_pkg::TPQ_RESET;
      upt_r <= mtep_pkg::UPT_RESET;
    end else begin
      if (cfg_wr_en) tpq_r <= cfg_wr_data;
      if (div_done) upt_r <= div_quo;
    end
  end

  assign div_dividend = cmd.div_default ? mtep_pkg::DEFAULT_TEMPO : tempo_nxt;

  mtep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && cmd.div_start),
    .dividend (div_dividend),
    .divisor  (tpq_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Delay: both operands are registers, result registered in the output stage
  assign product = delta_r * upt_r;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.emit) begin
      out_r.event_kind <= cmd.kind;
      out_r.delay_us   <= product;
      case (cmd.sel)
        mtep_pkg::SEL_CH_ONE: begin
          out_r.status_byte <= run_st_r;
          out_r.first_data  <= b;
          out_r.second_data <= '0;
          out_r.has_second  <= 1'b0;
        end
        mtep_pkg::SEL_CH_TWO: begin
          out_r.status_byte <= run_st_r;
          out_r.first_data  <= held_r;
          out_r.second_data <= b;
          out_r.has_second  <= 1'b1;
        end
        mtep_pkg::SEL_META: begin
          out_r.status_byte <= mtep_pkg::META_STATUS;
          out_r.first_data  <= meta_r;
          out_r.second_data <= '0;
          out_r.has_second  <= 1'b0;
        end
        default: begin
          out_r.status_byte <= b;
          out_r.first_data  <= '0;
          out_r.second_data <= '0;
          out_r.has_second  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/midi_track_event_parser_top.sv
// A result is registered and appears on out_data in the cycle after the byte that completes its event.
// Throughput: one byte per cycle while the divider is idle and the result register drains.
// A restart byte or the end of a tempo event runs the 24-step divider; no byte is
// taken until it has finished and its quotient is taken up as the new tick length.
// Reset (rst_n low, synchronous): parser back to delta time, ticks per quarter 96,
// 5208 us per tick, result register empty.
module midi_track_event_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mtep_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mtep_pkg::out_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [mtep_pkg::TPQ_W-1:0]    cfg_wr_data
);

  mtep_pkg::cmd_t  cmd;
  mtep_pkg::stat_t stat;
  logic            accept;
  logic            div_busy;

  // Take a byte when the divider is free and the result register can move
  assign in_ready = !div_busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  mtep_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .stat    (stat),
    .cmd     (cmd)
  );

  mtep_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .div_busy    (div_busy)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mtep_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;    // divider run plus margin
  localparam int PHASE_BYTES   = 215;   // seven settings, about 1500 requests in all
  localparam int NUM_PHASES    = 7;

  typedef enum logic [2:0] {
    TP_DELTA, TP_STATUS, TP_DATA1, TP_DATA2,
    TP_META_TYPE, TP_META_LEN, TP_META_BODY, TP_HALT
  } track_phase_e;

  // Track parser prediction and result checking
  class midi_scoreboard;
    logic [TPQ_W-1:0]   ticks_pq;
    track_phase_e       phase;
    logic [DELTA_W-1:0] delta_ticks;
    logic [UPT_W-1:0]   us_tick;
    logic [UPT_W-1:0]   tempo_acc;
    logic [7:0]         run_st, cur_st, held, mtype, left;
    out_t               expected_q[$];
    int                 mismatches;

    function new();
      ticks_pq   = TPQ_RESET;
      mismatches = 0;
      restart_track();
    endfunction

    static function bit takes_two(input logic [7:0] st);
      return st[7:4] != CLASS_PROG && st[7:4] != CLASS_PRESS;
    endfunction

    // zero ticks per quarter divides as one
    function logic [UPT_W-1:0] tick_length(input logic [UPT_W-1:0] tempo);
      logic [TPQ_W-1:0] d;
      d = (ticks_pq == '0) ? TPQ_W'(1) : ticks_pq;
      return tempo / UPT_W'(d);
    endfunction

    function void restart_track();
      phase       = TP_DELTA;
      delta_ticks = '0;
      us_tick     = tick_length(DEFAULT_TEMPO);
      tempo_acc   = '0;
      run_st      = '0;
      cur_st      = '0;
      held        = '0;
      mtype       = '0;
      left        = '0;
    endfunction

    function void push_event(input kind_t kind, input logic [7:0] st, input logic [7:0] d1,
                             input logic [7:0] d2, input logic has2);
      out_t e;
      e.event_kind  = kind;
      e.delay_us    = DELAY_W'(delta_ticks) * DELAY_W'(us_tick);
      e.status_byte = st;
      e.first_data  = d1;
      e.second_data = d2;
      e.has_second  = has2;
      expected_q.push_back(e);
      delta_ticks = '0;
      phase       = TP_DELTA;
    endfunction

    // delay uses the tempo in force before the meta event
    function void finish_meta(input bit had_body);
      bit eot;
      eot = (mtype == META_EOT);
      push_event(eot ? KIND_EOT : KIND_META, META_STATUS, mtype, 8'h00, 1'b0);
      if (mtype == META_TEMPO && had_body)
        us_tick = tick_length(tempo_acc);
      if (eot)
        phase = TP_HALT;
    endfunction

    function void note_request(input in_t req);
      logic [7:0] b;
      b = req.data_byte;
      if (req.track_start)
        restart_track();
      case (phase)
        TP_DELTA: begin
          delta_ticks = {delta_ticks[DELTA_W-8:0], b[6:0]};
          if (!b[7])
            phase = TP_STATUS;
        end
        TP_STATUS: begin
          if (b < STATUS_MIN) begin
            // running status
            cur_st = run_st;
            held   = b;
            if (takes_two(cur_st))
              phase = TP_DATA2;
            else
              push_event(KIND_CHANNEL, cur_st, b, 8'h00, 1'b0);
          end else if (b == META_STATUS) begin
            phase = TP_META_TYPE;
          end else if (b >= SYSTEM_MIN) begin
            push_event(KIND_SYSEX, b, 8'h00, 8'h00, 1'b0);
            phase = TP_HALT;
          end else begin
            cur_st = b;
            run_st = b;
            phase  = TP_DATA1;
          end
        end
        TP_DATA1: begin
          held = b;
          if (takes_two(cur_st))
            phase = TP_DATA2;
          else
            push_event(KIND_CHANNEL, cur_st, b, 8'h00, 1'b0);
        end
        TP_DATA2: push_event(KIND_CHANNEL, cur_st, held, b, 1'b1);
        TP_META_TYPE: begin
          mtype = b;
          phase = TP_META_LEN;
        end
        TP_META_LEN: begin
          left      = b;
          tempo_acc = '0;
          if (b == 8'h00)
            finish_meta(1'b0);
          else
            phase = TP_META_BODY;
        end
        TP_META_BODY: begin
          if (mtype == META_TEMPO)
            tempo_acc = {tempo_acc[UPT_W-9:0], b};
          left = left - 8'd1;
          if (left == 8'h00)
            finish_meta(1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d delay %0d status %02h d1 %02h d2 %02h has2 %0b",
                   got.event_kind, got.delay_us, got.status_byte, got.first_data,
                   got.second_data, got.has_second);
        return;
      end
      want = expected_q.pop_front();
      if (got.event_kind !== want.event_kind || got.delay_us !== want.delay_us ||
          got.status_byte !== want.status_byte || got.first_data !== want.first_data ||
          got.second_data !== want.second_data || got.has_second !== want.has_second) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch (exp/got): kind %0d/%0d delay %0d/%0d status %02h/%02h",
                    " d1 %02h/%02h d2 %02h/%02h has2 %0b/%0b"},
                   want.event_kind, got.event_kind, want.delay_us, got.delay_us,
                   want.status_byte, got.status_byte, want.first_data, got.first_data,
                   want.second_data, got.second_data, want.has_second, got.has_second);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_wr_en;
  logic [TPQ_W-1:0] cfg_wr_data;

  midi_scoreboard   sb;
  bit               start_next;
  bit               src_idle;
  bit               snk_idle;
  int               sent;
  int               cycles = 0;
  logic [TPQ_W-1:0] tpq_plan [NUM_PHASES];

  midi_track_event_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_data);
      if (in_valid && in_ready)
        sb.note_request(in_data);
      if (cfg_wr_en)
        sb.ticks_pq = cfg_wr_data;
    end
  end

  // Result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (snk_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // One byte request; returns at the edge that takes it
  task automatic send_byte(input logic [7:0] b);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= in_t'({start_next, b});
    start_next = 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Drain all results, then let a divider run finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [TPQ_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] data_any();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(0, 8'h7F));
  endfunction

  // Mostly one byte; now and then long enough to overflow the 28-bit count
  task automatic send_delta();
    int n;
    int x;
    x = $urandom_range(0, 99);
    n = (x < 70) ? 1 : (x < 90) ? $urandom_range(2, 3) : (x < 97) ? 4 : $urandom_range(5, 6);
    repeat (n - 1) send_byte({1'b1, 7'($urandom_range(0, 8'h7F))});
    send_byte({1'b0, 7'($urandom_range(0, 8'h7F))});
  endtask

  task automatic send_meta(input logic [7:0] mt, input logic [7:0] len);
    send_byte(META_STATUS);
    send_byte(mt);
    send_byte(len);
    repeat (len) send_byte(8'($urandom()));
  endtask

  // One track of random events, mostly well-formed, ending in a halt or the budget
  task automatic random_track(input int target);
    logic [7:0] st;
    logic [7:0] mt;
    logic [7:0] len;
    int         r;
    int         x;
    int         k;
    bit         ended;
    st         = 8'h00;
    ended      = 1'b0;
    start_next = 1'b1;
    while (!ended && sent < target) begin
      if ($urandom_range(0, 99) == 0)
        settle();
      send_delta();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 2) == 0 && (st != 8'h00 || $urandom_range(0, 9) == 0)) begin
          // running status
          send_byte(8'($urandom_range(0, 8'h7F)));
          if (midi_scoreboard::takes_two(st))
            send_byte(data_any());
        end else begin
          st = 8'($urandom_range(STATUS_MIN, SYSTEM_MIN - 1));
          send_byte(st);
          send_byte(data_any());
          if (midi_scoreboard::takes_two(st))
            send_byte(data_any());
        end
      end else if (r < 78) begin
        mt = 8'($urandom());
        if (mt == META_EOT || mt == META_TEMPO)
          mt = 8'h01;
        x   = $urandom_range(0, 99);
        len = (x < 20) ? 8'd0 : (x < 90) ? 8'($urandom_range(1, 6)) :
              (x < 99) ? 8'($urandom_range(7, 40)) : 8'd255;
        send_meta(mt, len);
      end else if (r < 90) begin
        len = ($urandom_range(0, 4) != 0) ? 8'd3 : 8'($urandom_range(0, 6));
        send_meta(META_TEMPO, len);
      end else if (r < 94) begin
        send_meta(META_EOT, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 2)) : 8'd0);
        ended = 1'b1;
      end else if (r < 97) begin
        send_byte(8'($urandom_range(SYSTEM_MIN, META_STATUS - 1)));
        ended = 1'b1;
      end else begin
        // broken event: stray bytes, then a restart
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom()));
        start_next = 1'b1;
        st         = 8'h00;
      end
    end
    // halted parser ignores these
    if (ended) begin
      k = $urandom_range(0, 3);
      repeat (k) send_byte(8'($urandom()));
      sent -= k;
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    start_next  = 1'b0;
    src_idle    = 1'b0;
    snk_idle    = 1'b0;
    sent        = 0;
    tpq_plan    = '{15'd1, 15'd32767, 15'd0, 15'd480,
                    TPQ_W'($urandom_range(2, 32766)), TPQ_W'($urandom_range(2, 1000)), TPQ_RESET};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: running status before any status, data with top bit set
    start_next = 1'b1;
    send_byte(8'h00);
    send_byte(8'h40);
    send_byte(8'hFF);
    // widest delta, program change
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hC3);
    send_byte(8'h7F);
    // delta past 28 bits, running one-byte message
    send_byte(8'h81);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h05);
    // tempo event with a random value
    send_byte(8'h00);
    send_meta(META_TEMPO, 8'd3);
    // channel pressure
    send_byte(8'h7F);
    send_byte(8'hD0);
    send_byte(8'h80);
    // end of track, then restart straight into a system status
    send_byte(8'h00);
    send_meta(META_EOT, 8'd0);
    start_next = 1'b1;
    send_byte(8'h00);
    send_byte(SYSTEM_MIN);
    settle();

    // Random tracks under each ticks-per-quarter setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_ticks(tpq_plan[p]);
      src_idle = (p < NUM_PHASES - 1) && (p % 4 != 2);
      snk_idle = (p < NUM_PHASES - 1) && (p % 4 != 1);
      begin
        int target;
        target = sent + PHASE_BYTES;
        while (sent < target) random_track(target);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
